>>> hw/rtl/vfs_pkg.sv
// Shared types and constants for the VAD frame segmenter.
// Item structs for both channels, configuration register indexes and field widths.
// No dependencies.
package vfs_pkg;

  localparam int FRAME_LEN_W = 11;
  localparam int WINDOW_LEN_W = 6;
  localparam int THRESHOLD_W = 6;
  localparam int MAX_SEG_W = 24;
  localparam int POS_W = 35;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG = 2'd3;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 11'd320;
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RST = 6'd10;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 6'd8;
  localparam logic [MAX_SEG_W-1:0] MAX_SEG_RST = 24'd2880000;

  typedef struct packed {
    logic voice;
    logic last_frame;
  } vfs_in_t;

  typedef struct packed {
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_end;
    logic last_piece;
  } vfs_out_t;

endpackage

>>> hw/rtl/vad_frame_segmenter.sv
// VAD frame segmenter: top level with sequencer, shared multiplier and divider.
// Depends on vfs_pkg.
//
// Usage: one item per frame on the input channel (voice flag, last_frame marker);
// segment pieces leave on the output channel as {seg_start, seg_end, last_piece}
// in sample units. Both channels use valid/stall; an item moves when valid is high
// and stall is low. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write it only while the block is idle; the block does not enforce this.
// Sequence: an item is held for flag counting over the window (one flag per cycle
// through a single adder) and then a decision step. A closing segment then uses the
// shared multiplier for segment start and end, runs the one-bit-per-cycle divider
// twice (piece count, then piece length) and emits pieces, up to MAX_PIECES. A final
// frame that flushes uses the multiplier for start and end and emits one piece.
// in_stall_o is high after acceptance until the decision or, if a segment closes,
// until the last piece is in the output register. A stalled receiver holds the
// output register and the sequencer waits.
// Reset clears the stream state and loads the default configuration.
module vad_frame_segmenter #(
  parameter int WINDOW_MAX = 32,
  parameter int FRAME_INDEX_BITS = 24,
  parameter int MAX_PIECES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [vfs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [vfs_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  vfs_pkg::vfs_in_t                      in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output vfs_pkg::vfs_out_t                     out_item_o
);

  localparam int FW = FRAME_INDEX_BITS;
  localparam int KW = FW + 1;
  localparam int PW = KW + vfs_pkg::FRAME_LEN_W;
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int IW = $clog2(WINDOW_MAX);
  localparam int NWC = (NW > vfs_pkg::WINDOW_LEN_W) ? NW : vfs_pkg::WINDOW_LEN_W;
  localparam int CNT_W = $clog2(MAX_PIECES);
  localparam int DCW = $clog2(PW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MULS = 3'd3;
  localparam logic [2:0] S_MULE = 3'd4;
  localparam logic [2:0] S_DIV1 = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // configuration
  logic [vfs_pkg::FRAME_LEN_W-1:0]  fl_q, fl_d;
  logic [vfs_pkg::WINDOW_LEN_W-1:0] wl_q, wl_d;
  logic [vfs_pkg::THRESHOLD_W-1:0]  thr_q, thr_d;
  logic [vfs_pkg::MAX_SEG_W-1:0]    mx_q, mx_d;

  // control and stream state
  logic [2:0]            state_q, state_d;
  logic [WINDOW_MAX-1:0] fwin_q, fwin_d;
  logic [NW-1:0]         sum_q, sum_d;
  logic [NW-1:0]         pc_q, pc_d;
  logic [NW-1:0]         skip_q, skip_d;
  logic                  spch_q, spch_d;
  logic [FW-1:0]         ostart_q, ostart_d;
  logic [FW-1:0]         fidx_q, fidx_d;
  logic                  last_q, last_d;
  logic                  final_q, final_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DCW-1:0]        dcnt_q, dcnt_d;
  logic                  out_valid_q, out_valid_d;

  // datapath
  logic [FW-1:0]     sfr_q, sfr_d;
  logic [KW-1:0]     efr_q, efr_d;
  logic [PW-1:0]     start_q, start_d;
  logic [PW-1:0]     end_q, end_d;
  logic [PW-1:0]     part_q, part_d;
  logic [PW-1:0]     plen_q, plen_d;
  logic [PW-1:0]     num_q, num_d;
  logic [PW-1:0]     rem_q, rem_d;
  logic [PW-1:0]     den_q, den_d;
  vfs_pkg::vfs_out_t out_q, out_d;

  logic [NW-1:0]  nwin;
  logic [KW-1:0]  kp1;
  logic           eval_win, short_strm, sum_ge;
  logic [KW-1:0]  mul_a;
  logic [PW-1:0]  prod;
  logic [PW:0]    div_rs;
  logic [PW+1:0]  div_sub;
  logic           div_ge;
  logic [PW-1:0]  div_q;
  logic [PW+1:0]  sstep;
  logic           more;
  logic           out_free;
  logic [vfs_pkg::MAX_SEG_W-1:0] mx1;

  always_comb begin
    if (wl_q == '0) begin
      nwin = NW'(1);
    end else if (NWC'(wl_q) > NWC'(WINDOW_MAX)) begin
      nwin = NW'(WINDOW_MAX);
    end else begin
      nwin = NW'(wl_q);
    end
  end

  assign kp1 = KW'(fidx_q) + KW'(1);
  assign eval_win = kp1 >= KW'(nwin);
  assign short_strm = kp1 <= KW'(nwin);
  assign sum_ge = NWC'(sum_q) >= NWC'(thr_q);
  assign mx1 = (mx_q == '0) ? vfs_pkg::MAX_SEG_W'(1) : mx_q;

  // shared multiplier: frame number times frame length
  assign mul_a = (state_q == S_MULS) ? KW'(sfr_q) : efr_q;
  assign prod = PW'(mul_a) * PW'(fl_q);

  // shared restoring divider, one quotient bit per cycle
  assign div_rs = {rem_q, num_q[PW-1]};
  assign div_sub = {1'b0, div_rs} - {2'b00, den_q};
  assign div_ge = ~div_sub[PW+1];
  assign div_q = {num_q[PW-2:0], div_ge};

  assign sstep = {2'b00, start_q} + {1'b0, plen_q, 1'b0};
  assign more = !final_q && (cnt_q != CNT_W'(MAX_PIECES - 1)) && (sstep < {2'b00, end_q});
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fl_d = fl_q;
    wl_d = wl_q;
    thr_d = thr_q;
    mx_d = mx_q;
    state_d = state_q;
    fwin_d = fwin_q;
    sum_d = sum_q;
    pc_d = pc_q;
    skip_d = skip_q;
    spch_d = spch_q;
    ostart_d = ostart_q;
    fidx_d = fidx_q;
    last_d = last_q;
    final_d = final_q;
    cnt_d = cnt_q;
    dcnt_d = dcnt_q;
    sfr_d = sfr_q;
    efr_d = efr_q;
    start_d = start_q;
    end_d = end_q;
    part_d = part_q;
    plen_d = plen_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vfs_pkg::CFG_FRAME_LEN:  fl_d = cfg_wdata_i[vfs_pkg::FRAME_LEN_W-1:0];
        vfs_pkg::CFG_WINDOW_LEN: wl_d = cfg_wdata_i[vfs_pkg::WINDOW_LEN_W-1:0];
        vfs_pkg::CFG_THRESHOLD:  thr_d = cfg_wdata_i[vfs_pkg::THRESHOLD_W-1:0];
        vfs_pkg::CFG_MAX_SEG:    mx_d = cfg_wdata_i[vfs_pkg::MAX_SEG_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fwin_d = {fwin_q[WINDOW_MAX-2:0], in_item_i.voice};
          last_d = in_item_i.last_frame;
          sum_d = '0;
          pc_d = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d = sum_q + NW'(fwin_q[pc_q[IW-1:0]]);
        pc_d = pc_q + NW'(1);
        if (pc_q == nwin - NW'(1)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        if (last_q) begin
          final_d = 1'b1;
          efr_d = KW'(fidx_q);
          if (short_strm) begin
            sfr_d = '0;
            state_d = S_MULS;
          end else if (spch_q) begin
            sfr_d = ostart_q;
            state_d = S_MULS;
          end
          fwin_d = '0;
          spch_d = 1'b0;
          ostart_d = '0;
          fidx_d = '0;
          skip_d = '0;
        end else begin
          if (eval_win) begin
            priority if (skip_q != '0) begin
              skip_d = skip_q - NW'(1);
            end else if (!spch_q && sum_ge) begin
              spch_d = 1'b1;
              ostart_d = FW'(kp1 - KW'(nwin));
            end else if (spch_q && !sum_ge) begin
              spch_d = 1'b0;
              skip_d = nwin;
              sfr_d = ostart_q;
              efr_d = kp1;
              final_d = 1'b0;
              state_d = S_MULS;
            end else begin
              // segment state unchanged
            end
          end
          if (fidx_q != '1) begin
            fidx_d = FW'(kp1);
          end
        end
      end
      S_MULS: begin
        start_d = prod;
        state_d = S_MULE;
      end
      S_MULE: begin
        end_d = prod;
        part_d = prod - start_q;
        num_d = prod - start_q;
        den_d = PW'(mx1);
        rem_d = '0;
        dcnt_d = '0;
        cnt_d = '0;
        state_d = final_q ? S_EMIT : S_DIV1;
      end
      S_DIV1, S_DIV2: begin
        num_d = div_q;
        rem_d = div_ge ? div_sub[PW-1:0] : div_rs[PW-1:0];
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(PW - 1)) begin
          dcnt_d = '0;
          if (state_q == S_DIV1) begin
            num_d = part_q;
            den_d = div_q + PW'(1);
            rem_d = '0;
            state_d = S_DIV2;
          end else begin
            plen_d = div_q;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.seg_start = (vfs_pkg::POS_W)'(start_q);
          if (more) begin
            out_d.seg_end = (vfs_pkg::POS_W)'(start_q + plen_q);
            out_d.last_piece = 1'b0;
            start_d = start_q + plen_q;
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            out_d.seg_end = (vfs_pkg::POS_W)'(end_q);
            out_d.last_piece = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q <= vfs_pkg::FRAME_LEN_RST;
      wl_q <= vfs_pkg::WINDOW_LEN_RST;
      thr_q <= vfs_pkg::THRESHOLD_RST;
      mx_q <= vfs_pkg::MAX_SEG_RST;
      state_q <= S_IDLE;
      fwin_q <= '0;
      sum_q <= '0;
      pc_q <= '0;
      skip_q <= '0;
      spch_q <= 1'b0;
      ostart_q <= '0;
      fidx_q <= '0;
      last_q <= 1'b0;
      final_q <= 1'b0;
      cnt_q <= '0;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fl_q <= fl_d;
      wl_q <= wl_d;
      thr_q <= thr_d;
      mx_q <= mx_d;
      state_q <= state_d;
      fwin_q <= fwin_d;
      sum_q <= sum_d;
      pc_q <= pc_d;
      skip_q <= skip_d;
      spch_q <= spch_d;
      ostart_q <= ostart_d;
      fidx_q <= fidx_d;
      last_q <= last_d;
      final_q <= final_d;
      cnt_q <= cnt_d;
      dcnt_q <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sfr_q <= sfr_d;
    efr_q <= efr_d;
    start_q <= start_d;
    end_q <= end_d;
    part_q <= part_d;
    plen_q <= plen_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    out_q <= out_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  a_accept_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_SUM)
    else $error("accepted item did not start the flag count");

  a_open_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spch_q |-> ostart_q <= fidx_q)
    else $error("open segment starts after the current frame");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV1 || state_q == S_DIV2) |-> den_q != '0)
    else $error("divider running with zero divisor");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> start_q <= end_q)
    else $error("piece start passed segment end");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= NW'(WINDOW_MAX))
    else $error("skip count above window maximum");

endmodule
